[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the dual key record index.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define DKRI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DKRI_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/dkri_pkg.sv]
// Package for the dual key record index: entry and control types, codes, constants.
// No dependencies; used by dkri_cell and dual_key_record_index.
package dkri_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam logic [6:0] MAX_ENTRIES_RST = 7'd64;
   localparam logic [31:0] BASE_OFFSET = 32'd12;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] SPACE_FIRST  = 2'd1;
   localparam logic [1:0] SPACE_SECOND = 2'd2;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_FULL      = 3'd1;
   localparam logic [2:0] STS_DUPLICATE = 3'd2;
   localparam logic [2:0] STS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STS_OVERFLOW  = 3'd4;

   typedef struct packed {
      logic [30:0] key;
      logic [31:0] off;
      logic [15:0] len;
   } entry_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic [30:0] a_key;    // arrival key compare / insert value
      logic [30:0] s_key;    // sorted key compare / insert value
      logic [31:0] a_off;    // offset looked up among sorted entries
      logic [31:0] s_off;    // offset looked up among arrival entries
      logic [31:0] new_off;
      logic [15:0] new_len;
      logic        ins;
      logic        del;
   } ctl_type;

   typedef struct packed {
      logic amatch;
      logic smatch;
      logic sgt;
      logic slink;
      logic alink;
   } flag_type;

endpackage

[hdl/dkri_cell.sv]
// One cell of the index chain: holds one arrival entry and one sorted entry.
// Depends on dkri_pkg; instantiated in a row by dual_key_record_index.
module dkri_cell #(
   parameter int DEPTH = dkri_pkg::TABLE_DEPTH_DEF,
   parameter int IDX   = 0,
   localparam int CW   = $clog2(DEPTH + 1),
   localparam int IW   = $clog2(DEPTH)
) (
   input  logic                clock,
   input  dkri_pkg::ctl_type   ctl,
   input  logic [CW-1:0]       count,
   input  logic [IW-1:0]       del_a_idx,
   input  logic [IW-1:0]       del_s_idx,
   input  dkri_pkg::entry_type prev_s,
   input  logic                prev_sgt,
   input  dkri_pkg::entry_type next_a,
   input  dkri_pkg::entry_type next_s,
   output dkri_pkg::entry_type a_q,
   output dkri_pkg::entry_type s_q,
   output dkri_pkg::flag_type  flags
);

   dkri_pkg::entry_type a_ff, a_in, s_ff, s_in;
   logic live, at_end;

   always_comb begin
      live   = CW'(IDX) < count;
      at_end = CW'(IDX) == count;
      flags.amatch = live && (a_ff.key == ctl.a_key);
      flags.smatch = live && (s_ff.key == ctl.s_key);
      flags.sgt    = live && (s_ff.key > ctl.s_key);
      flags.slink  = live && (s_ff.off == ctl.a_off);
      flags.alink  = live && (a_ff.off == ctl.s_off);
   end

   always_comb begin
      a_in = a_ff;
      s_in = s_ff;
      if (ctl.ins) begin
         if (at_end) begin
            a_in = '{key: ctl.a_key, off: ctl.new_off, len: ctl.new_len};
         end
         // entries above the insertion point move up one cell
         if (prev_sgt) begin
            s_in = prev_s;
         end else if (flags.sgt || at_end) begin
            s_in = '{key: ctl.s_key, off: ctl.new_off, len: ctl.new_len};
         end
      end else if (ctl.del) begin
         if (IW'(IDX) >= del_a_idx) begin
            a_in = next_a;
         end
         if (IW'(IDX) >= del_s_idx) begin
            s_in = next_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      s_ff <= s_in;
   end

   assign a_q = a_ff;
   assign s_q = s_ff;

endmodule

[hdl/dual_key_record_index.sv]
// Dual key record index: each item is one command (insert, find or delete), and
// each gives exactly one result, strobed on rsp_valid for a single cycle; there
// is no way to hold results off, so a receiver must take them as they come.
// Timing: busy is high from the accepting edge until the result strobe. A
// find, a delete or an insert into a table that is not full sweeps the live
// entries once for key matches, and find/delete sweep again to pair the two
// spaces by offset. The sweeps step a one-bit-per-cycle scan over flag
// vectors captured from the cell row, so the time taken grows with the
// entries held.
// Depends on dkri_pkg, dkri_cell and assert_macros.svh.
`include "assert_macros.svh"

module dual_key_record_index #(
   parameter int TABLE_DEPTH = dkri_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [30:0] req_key_a,
   input  logic [30:0] req_key_b,
   input  logic [15:0] req_record_length,
   input  logic [1:0]  req_key_space,
   // result channel
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_found_first,
   output logic [30:0] rsp_first_other_key,
   output logic [31:0] rsp_first_offset,
   output logic [15:0] rsp_first_length,
   output logic        rsp_found_second,
   output logic [30:0] rsp_second_other_key,
   output logic [31:0] rsp_second_offset,
   output logic [15:0] rsp_second_length,
   output logic [6:0]  rsp_entries_held,
   // capacity register
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FLAGS  = 4'd1;  // capture key match vectors
   localparam logic [3:0] ST_SCAN1  = 4'd2;  // find matching indexes
   localparam logic [3:0] ST_RD1    = 4'd3;  // read matched entries
   localparam logic [3:0] ST_INSC   = 4'd4;  // insert: new offset, write
   localparam logic [3:0] ST_LFLAGS = 4'd5;  // capture offset link vectors
   localparam logic [3:0] ST_SCAN2  = 4'd6;  // find partner indexes
   localparam logic [3:0] ST_RD2    = 4'd7;  // read partner entries
   localparam logic [3:0] ST_FIN    = 4'd8;  // find/delete result

   logic [3:0] state_ff, state_in;

   // latched command
   logic [1:0]  cmd_ff, cmd_in;
   logic [30:0] ka_ff, ka_in, kb_ff, kb_in;
   logic [15:0] len_ff, len_in;
   logic [1:0]  space_ff, space_in;

   logic [CW-1:0] count_ff, count_in;
   logic [6:0]    maxent_ff, maxent_in;

   // scan state
   logic [TABLE_DEPTH-1:0] v1_ff, v1_in, v2_ff, v2_in;
   logic [CW-1:0] k_ff, k_in;
   logic fa_ff, fa_in, fs_ff, fs_in, lf1_ff, lf1_in, lf2_ff, lf2_in;
   logic [IW-1:0] ai_ff, ai_in, si_ff, si_in, lai_ff, lai_in, lsi_ff, lsi_in;

   dkri_pkg::entry_type rda_ff, rda_in, rds_ff, rds_in;
   dkri_pkg::entry_type rdxa_ff, rdxa_in, rdxs_ff, rdxs_in;

   // result registers
   logic        rv_ff, rv_in;
   logic [2:0]  st_ff, st_in;
   logic        ff1_ff, ff1_in, ff2_ff, ff2_in;
   logic [30:0] ok1_ff, ok1_in, ok2_ff, ok2_in;
   logic [31:0] of1_ff, of1_in, of2_ff, of2_in;
   logic [15:0] ln1_ff, ln1_in, ln2_ff, ln2_in;

   // cell row
   dkri_pkg::ctl_type   ctl;
   dkri_pkg::entry_type a_q [TABLE_DEPTH];
   dkri_pkg::entry_type s_q [TABLE_DEPTH];
   dkri_pkg::flag_type  flg [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] amatch_v, smatch_v, slink_v, alink_v;
   logic [IW-1:0] del_a_idx, del_s_idx, rd_a_idx;

   logic        full, scan_done, found1, found2;
   logic [32:0] next_sum;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         dkri_cell #(.DEPTH(TABLE_DEPTH), .IDX(g)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .count     (count_ff),
            .del_a_idx (del_a_idx),
            .del_s_idx (del_s_idx),
            .prev_s    ((g == 0) ? s_q[g] : s_q[(g == 0) ? 0 : g - 1]),
            .prev_sgt  ((g == 0) ? 1'b0 : flg[(g == 0) ? 0 : g - 1].sgt),
            .next_a    ((g == TABLE_DEPTH - 1) ? a_q[g] :
                        a_q[(g == TABLE_DEPTH - 1) ? g : g + 1]),
            .next_s    ((g == TABLE_DEPTH - 1) ? s_q[g] :
                        s_q[(g == TABLE_DEPTH - 1) ? g : g + 1]),
            .a_q       (a_q[g]),
            .s_q       (s_q[g]),
            .flags     (flg[g])
         );
         assign amatch_v[g] = flg[g].amatch;
         assign smatch_v[g] = flg[g].smatch;
         assign slink_v[g]  = flg[g].slink;
         assign alink_v[g]  = flg[g].alink;
      end
   endgenerate

   // full when count >= min(max_entries, depth)
   assign full = (32'(count_ff) >= 32'(maxent_ff)) || (count_ff >= CW'(TABLE_DEPTH));
   assign scan_done = (k_ff == count_ff);
   assign found1 = fa_ff && lf1_ff;
   assign found2 = fs_ff && lf2_ff;

   // next insert offset: after the newest arrival entry, or the base
   assign next_sum = (count_ff == '0) ? {1'b0, dkri_pkg::BASE_OFFSET}
                     : {1'b0, rda_ff.off} + 33'(rda_ff.len);

   assign rd_a_idx = (cmd_ff == dkri_pkg::CMD_INSERT) ? IW'(count_ff - CW'(1)) : ai_ff;

   // pair indexes to remove, by the space that was searched
   assign del_a_idx = (space_ff == dkri_pkg::SPACE_FIRST) ? ai_ff : lai_ff;
   assign del_s_idx = (space_ff == dkri_pkg::SPACE_FIRST) ? lsi_ff : si_ff;

   always_comb begin
      ctl.a_key   = ka_ff;
      ctl.s_key   = (cmd_ff == dkri_pkg::CMD_INSERT) ? kb_ff : ka_ff;
      ctl.a_off   = rda_ff.off;
      ctl.s_off   = rds_ff.off;
      ctl.new_off = next_sum[31:0];
      ctl.new_len = len_ff;
      ctl.ins     = (state_ff == ST_INSC) && !next_sum[32];
      ctl.del     = (state_ff == ST_FIN) && (cmd_ff == dkri_pkg::CMD_DELETE)
                    && (((space_ff == dkri_pkg::SPACE_FIRST) && found1)
                        || ((space_ff == dkri_pkg::SPACE_SECOND) && found2));
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; ka_in = ka_ff; kb_in = kb_ff; len_in = len_ff; space_in = space_ff;
      count_in = count_ff;
      maxent_in = csr_wr_en ? csr_wr_data : maxent_ff;
      v1_in = v1_ff; v2_in = v2_ff; k_in = k_ff;
      fa_in = fa_ff; fs_in = fs_ff; lf1_in = lf1_ff; lf2_in = lf2_ff;
      ai_in = ai_ff; si_in = si_ff; lai_in = lai_ff; lsi_in = lsi_ff;
      rda_in = rda_ff; rds_in = rds_ff; rdxa_in = rdxa_ff; rdxs_in = rdxs_ff;
      rv_in = 1'b0; st_in = dkri_pkg::STS_NOT_FOUND;
      ff1_in = 1'b0; ok1_in = '0; of1_in = '0; ln1_in = '0;
      ff2_in = 1'b0; ok2_in = '0; of2_in = '0; ln2_in = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_cmd; ka_in = req_key_a; kb_in = req_key_b;
               len_in = req_record_length; space_in = req_key_space;
               state_in = ST_FLAGS;
            end
         end
         ST_FLAGS: begin
            v1_in = amatch_v; v2_in = smatch_v; k_in = '0;
            fa_in = 1'b0; fs_in = 1'b0;
            if (cmd_ff == dkri_pkg::CMD_INSERT && full) begin
               rv_in = 1'b1; st_in = dkri_pkg::STS_FULL; state_in = ST_IDLE;
            end else if (cmd_ff != dkri_pkg::CMD_INSERT && cmd_ff != dkri_pkg::CMD_FIND
                         && cmd_ff != dkri_pkg::CMD_DELETE) begin
               rv_in = 1'b1; state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN1;
            end
         end
         ST_SCAN1: begin
            if (scan_done) begin
               state_in = ST_RD1;
            end else begin
               if (v1_ff[0] && !fa_ff) begin fa_in = 1'b1; ai_in = k_ff[IW-1:0]; end
               if (v2_ff[0] && !fs_ff) begin fs_in = 1'b1; si_in = k_ff[IW-1:0]; end
               v1_in = v1_ff >> 1; v2_in = v2_ff >> 1;
               k_in = k_ff + CW'(1);
            end
         end
         ST_RD1: begin
            rda_in = a_q[rd_a_idx];
            rds_in = s_q[si_ff];
            if (cmd_ff == dkri_pkg::CMD_INSERT) begin
               if (fa_ff || fs_ff) begin
                  rv_in = 1'b1; st_in = dkri_pkg::STS_DUPLICATE; state_in = ST_IDLE;
               end else begin
                  state_in = ST_INSC;
               end
            end else begin
               state_in = ST_LFLAGS;
            end
         end
         ST_INSC: begin
            rv_in = 1'b1; state_in = ST_IDLE;
            if (next_sum[32]) begin
               st_in = dkri_pkg::STS_OVERFLOW;
            end else begin
               st_in = dkri_pkg::STS_OK; ff1_in = 1'b1;
               of1_in = next_sum[31:0]; ln1_in = len_ff;
               count_in = count_ff + CW'(1);
            end
         end
         ST_LFLAGS: begin
            v1_in = slink_v; v2_in = alink_v; k_in = '0;
            lf1_in = 1'b0; lf2_in = 1'b0;
            state_in = ST_SCAN2;
         end
         ST_SCAN2: begin
            if (scan_done) begin
               state_in = ST_RD2;
            end else begin
               if (v1_ff[0] && !lf1_ff) begin lf1_in = 1'b1; lsi_in = k_ff[IW-1:0]; end
               if (v2_ff[0] && !lf2_ff) begin lf2_in = 1'b1; lai_in = k_ff[IW-1:0]; end
               v1_in = v1_ff >> 1; v2_in = v2_ff >> 1;
               k_in = k_ff + CW'(1);
            end
         end
         ST_RD2: begin
            rdxa_in = a_q[lai_ff];
            rdxs_in = s_q[lsi_ff];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rv_in = 1'b1; state_in = ST_IDLE;
            if (cmd_ff == dkri_pkg::CMD_FIND) begin
               st_in = (found1 || found2) ? dkri_pkg::STS_OK : dkri_pkg::STS_NOT_FOUND;
               if (found1) begin
                  ff1_in = 1'b1; ok1_in = rdxs_ff.key;
                  of1_in = rda_ff.off; ln1_in = rda_ff.len;
               end
               if (found2) begin
                  ff2_in = 1'b1; ok2_in = rdxa_ff.key;
                  of2_in = rds_ff.off; ln2_in = rds_ff.len;
               end
            end else if (ctl.del) begin
               st_in = dkri_pkg::STS_OK;
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         maxent_ff <= dkri_pkg::MAX_ENTRIES_RST;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         maxent_ff <= maxent_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; ka_ff <= ka_in; kb_ff <= kb_in; len_ff <= len_in;
      space_ff <= space_in;
      v1_ff <= v1_in; v2_ff <= v2_in; k_ff <= k_in;
      fa_ff <= fa_in; fs_ff <= fs_in; lf1_ff <= lf1_in; lf2_ff <= lf2_in;
      ai_ff <= ai_in; si_ff <= si_in; lai_ff <= lai_in; lsi_ff <= lsi_in;
      rda_ff <= rda_in; rds_ff <= rds_in; rdxa_ff <= rdxa_in; rdxs_ff <= rdxs_in;
      st_ff <= st_in;
      ff1_ff <= ff1_in; ok1_ff <= ok1_in; of1_ff <= of1_in; ln1_ff <= ln1_in;
      ff2_ff <= ff2_in; ok2_ff <= ok2_in; of2_ff <= of2_in; ln2_ff <= ln2_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rv_ff;
   assign rsp_status           = st_ff;
   assign rsp_found_first      = ff1_ff;
   assign rsp_first_other_key  = ok1_ff;
   assign rsp_first_offset     = of1_ff;
   assign rsp_first_length     = ln1_ff;
   assign rsp_found_second     = ff2_ff;
   assign rsp_second_other_key = ok2_ff;
   assign rsp_second_offset    = of2_ff;
   assign rsp_second_length    = ln2_ff;
   assign rsp_entries_held     = 7'(count_ff);

   // a result strobe always lands back in idle
   `DKRI_ASSERT_NR(a_rsp_idle, clock, rv_ff |-> !busy, "result while busy")
   // entry count stays within the table
   `DKRI_ASSERT(a_count_max, clock, reset, count_ff <= CW'(TABLE_DEPTH), "count too big")
   // an accepted item leaves idle at once
   `DKRI_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "start ignored")
   // the entry count moves only with a result
   `DKRI_ASSERT(a_count_rsp, clock, reset, !$stable(count_ff) |-> rv_ff,
                "count changed without a result")

endmodule
